@@ sv/bdsr_pkg.sv @@
// bdsr_pkg: request/response payload types, request and status codes, and the
// per-cycle command struct broadcast to the cells of the deque.
// No dependencies.
package bdsr_pkg;

	localparam logic [2:0] REQ_PUSH_FRONT = 3'd0;
	localparam logic [2:0] REQ_PUSH_BACK  = 3'd1;
	localparam logic [2:0] REQ_POP_FRONT  = 3'd2;
	localparam logic [2:0] REQ_POP_BACK   = 3'd3;
	localparam logic [2:0] REQ_SEARCH     = 3'd4;
	localparam logic [2:0] REQ_REMOVE     = 3'd5;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_EMPTY    = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;
	localparam logic [1:0] ST_NOTFOUND = 2'd3;

	typedef struct packed {
		logic        [2:0]  req_type;
		logic signed [31:0] value;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [4:0] entry_count;
		logic       list_empty;
	} rsp_t;

	// Broadcast to every cell for the transfer being applied this cycle.
	typedef struct packed {
		logic               push_front; // take left neighbor, cell 0 takes value
		logic               push_back;  // cell at index count takes value
		logic               pop_front;  // every cell takes right neighbor
		logic               remove;     // cells at or past first match take right
		logic signed [31:0] value;
	} cmd_t;

endpackage

@@ sv/bdsr_cell.sv @@
// bdsr_cell: one entry of the deque plus its slice of the first-match chain.
// Depends on bdsr_pkg (cmd_t).
module bdsr_cell import bdsr_pkg::*; #(
	parameter int CNT_W = 5,
	parameter int IDX   = 0
) (
	input  logic               clk,
	input  cmd_t               cmd,
	input  logic [CNT_W-1:0]   count,
	input  logic signed [31:0] left_data,
	input  logic signed [31:0] right_data,
	input  logic               hit_in,
	output logic               hit_out,
	output logic signed [31:0] data
);

	localparam logic [CNT_W-1:0] IDX_C = CNT_W'(IDX);

	logic signed [31:0] data_q;
	logic               occupied;
	logic               match;

	assign occupied = count > IDX_C;
	assign match    = occupied && (data_q == cmd.value);
	assign hit_out  = hit_in | match;
	assign data     = data_q;

	// entry storage has no reset; only slots below count are ever observed
	always_ff @(posedge clk) begin
		if (cmd.push_front) begin
			data_q <= left_data;
		end else if (cmd.push_back && count == IDX_C) begin
			data_q <= cmd.value;
		end else if (cmd.pop_front || (cmd.remove && hit_out)) begin
			data_q <= right_data;
		end
	end

endmodule

@@ sv/bounded_deque_search_remove.sv @@
// bounded_deque_search_remove: top level, a row of bdsr_cell entries with
// count and response register.  Depends on bdsr_pkg and bdsr_cell.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-----------------------------
//  req     | in        | req_valid / req_stall | req_t  {req_type, value}
//  rsp     | out       | rsp_valid / rsp_stall | rsp_t  {status, entry_count,
//          |           |                       |         list_empty}
//
// One request per cycle while req_stall is low: every cell compares against the value at once, the
// first-match flag ripples down the row, and all cells shift in the same edge.
// The response is registered and appears in the cycle after the request transfer.
// req_stall is raised only while a held response is itself stalled.
// Reset clears count and the response valid; entry contents are not reset.
module bounded_deque_search_remove import bdsr_pkg::*; #(
	parameter int CAPACITY = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	localparam int               CNT_W = $clog2(CAPACITY + 1);
	localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);
	localparam logic [CNT_W-1:0] ONE_C = CNT_W'(1);

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_nxt;
	logic             rsp_valid_q;
	rsp_t             rsp_q;
	logic [1:0]       status;
	logic             take;
	logic             full;
	logic             empty;
	logic             found;
	cmd_t             cmd;
	logic [CNT_W+4:0] count_ext;

	logic signed [31:0] cell_data [CAPACITY];
	logic [CAPACITY:0]  hit;

	// a held response only blocks input while it is stalled itself
	assign req_stall = rsp_valid_q & rsp_stall;
	assign take      = req_valid & ~req_stall;
	assign full      = count_q == CAP_C;
	assign empty     = count_q == '0;
	assign found     = hit[CAPACITY];

	// cell commands; guarded here so the row only moves on a real change
	always_comb begin
		cmd.value      = req.value;
		cmd.push_front = take && req.req_type == REQ_PUSH_FRONT && !full;
		cmd.push_back  = take && req.req_type == REQ_PUSH_BACK && !full;
		cmd.pop_front  = take && req.req_type == REQ_POP_FRONT && !empty;
		cmd.remove     = take && req.req_type == REQ_REMOVE;
	end

	// status and next count
	always_comb begin
		status    = ST_OK;
		count_nxt = count_q;
		unique case (req.req_type)
			REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
				if (full) status = ST_FULL;
				else      count_nxt = count_q + ONE_C;
			end
			REQ_POP_FRONT, REQ_POP_BACK: begin
				if (empty) status = ST_EMPTY;
				else       count_nxt = count_q - ONE_C;
			end
			REQ_SEARCH: begin
				if (empty)       status = ST_EMPTY;
				else if (!found) status = ST_NOTFOUND;
			end
			REQ_REMOVE: begin
				if (empty)       status = ST_EMPTY;
				else if (!found) status = ST_NOTFOUND;
				else             count_nxt = count_q - ONE_C;
			end
			default: begin
				// unused codes leave the list alone and report ok
			end
		endcase
	end

	// the row of cells; hit[i] means a match sits ahead of cell i
	assign hit[0] = 1'b0;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [31:0] left_d;
		logic signed [31:0] right_d;

		if (i == 0) begin : g_first
			assign left_d = req.value;
		end else begin : g_mid
			assign left_d = cell_data[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_d = cell_data[i];
		end else begin : g_inner
			assign right_d = cell_data[i+1];
		end

		bdsr_cell #(
			.CNT_W (CNT_W),
			.IDX   (i)
		) u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.count      (count_q),
			.left_data  (left_d),
			.right_data (right_d),
			.hit_in     (hit[i]),
			.hit_out    (hit[i+1]),
			.data       (cell_data[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (take) begin
				count_q     <= count_nxt;
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// entry_count carries the low five bits of the count
	assign count_ext = {5'b0, count_nxt};

	always_ff @(posedge clk) begin
		if (take) begin
			rsp_q.status      <= status;
			rsp_q.entry_count <= count_ext[4:0];
			rsp_q.list_empty  <= count_nxt == '0;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

@@ dv/testbench.sv @@
// testbench: self-checking bench for bounded_deque_search_remove with a queue-fed driver,
// a response monitor and a shadow-list predictor of status, count and empty flag.
// Depends on bdsr_pkg and the bounded_deque_search_remove RTL.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import bdsr_pkg::*;

	localparam int CAPACITY = 16;

	// request codes the block must ignore (status ok, list untouched)
	localparam logic [2:0] REQ_UNUSED_LO = 3'd6;
	localparam logic [2:0] REQ_UNUSED_HI = 3'd7;

	localparam int RANDOM_PER_PHASE = 412;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	bounded_deque_search_remove #(
		.CAPACITY(CAPACITY)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp      (rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Requests waiting to be driven, in order.
	req_t pending_reqs[$];
	// Shadow of the deque contents, front at index 0.
	logic signed [31:0] shadow_list[$];
	// Responses predicted for accepted requests, oldest first.
	rsp_t expected_rsps[$];

	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned mismatch_cnt = 0;
	// Set at each rising edge: a request transfer happened at that edge.
	bit req_taken = 1'b0;

	// Small value pool so searches and removes actually hit stored entries.
	logic signed [31:0] value_pool[6];

	// Apply one request to the shadow list and return the response it must produce.
	function automatic rsp_t apply_request(req_t r);
		rsp_t res;
		int hit_pos;
		res = '0;
		res.status = ST_OK;
		hit_pos = -1;
		case (r.req_type)
			REQ_PUSH_FRONT: begin
				if (shadow_list.size() >= CAPACITY) res.status = ST_FULL;
				else shadow_list.push_front(r.value);
			end
			REQ_PUSH_BACK: begin
				if (shadow_list.size() >= CAPACITY) res.status = ST_FULL;
				else shadow_list.push_back(r.value);
			end
			REQ_POP_FRONT: begin
				if (shadow_list.size() == 0) res.status = ST_EMPTY;
				else void'(shadow_list.pop_front());
			end
			REQ_POP_BACK: begin
				if (shadow_list.size() == 0) res.status = ST_EMPTY;
				else void'(shadow_list.pop_back());
			end
			REQ_SEARCH, REQ_REMOVE: begin
				if (shadow_list.size() == 0) begin
					res.status = ST_EMPTY;
				end else begin
					// first match from the front wins
					for (int i = 0; i < shadow_list.size(); i++)
						if (hit_pos < 0 && shadow_list[i] == r.value) hit_pos = i;
					if (hit_pos < 0) res.status = ST_NOTFOUND;
					else if (r.req_type == REQ_REMOVE) shadow_list.delete(hit_pos);
				end
			end
			default: ;
		endcase
		res.entry_count = 5'(shadow_list.size());
		res.list_empty = (shadow_list.size() == 0);
		return res;
	endfunction

	function automatic logic signed [31:0] pick_value();
		if ($urandom_range(99) < 70) return value_pool[$urandom_range(5)];
		return $urandom;
	endfunction

	// mode 0 leans toward pushes (reaches full), 1 toward pops and removes
	// (reaches empty), 2 is an even mix.
	function automatic req_t random_request(int unsigned mode);
		req_t r;
		int unsigned roll;
		int unsigned c_pf, c_pb, c_popf, c_popb, c_srch;
		roll = $urandom_range(99);
		case (mode)
			0: begin c_pf = 40; c_pb = 75; c_popf = 82; c_popb = 88; c_srch = 94; end
			1: begin c_pf = 10; c_pb = 20; c_popf = 45; c_popb = 65; c_srch = 80; end
			default: begin c_pf = 20; c_pb = 40; c_popf = 52; c_popb = 64; c_srch = 82; end
		endcase
		if (roll < 3) r.req_type = $urandom_range(1) ? REQ_UNUSED_HI : REQ_UNUSED_LO;
		else if (roll < c_pf) r.req_type = REQ_PUSH_FRONT;
		else if (roll < c_pb) r.req_type = REQ_PUSH_BACK;
		else if (roll < c_popf) r.req_type = REQ_POP_FRONT;
		else if (roll < c_popb) r.req_type = REQ_POP_BACK;
		else if (roll < c_srch) r.req_type = REQ_SEARCH;
		else r.req_type = REQ_REMOVE;
		r.value = pick_value();
		return r;
	endfunction

	task automatic queue_req(logic [2:0] code, logic signed [31:0] val);
		req_t r;
		r.req_type = code;
		r.value = val;
		pending_reqs.push_back(r);
	endtask

	// Driver: inputs change on the falling edge. A held request stays put until
	// its transfer; a new one (or idle) follows only after that.
	always @(negedge clk) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			rsp_stall <= 1'b0;
		end else begin
			if (!req_valid || req_taken) begin
				if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					req <= pending_reqs.pop_front();
					req_valid <= 1'b1;
				end else begin
					req_valid <= 1'b0;
				end
			end
			rsp_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// Monitor: sample both channels on the rising edge. The response to a
	// request is registered and shows up in the next cycle at the earliest, so checking before
	// predicting in the same edge is safe.
	always @(posedge clk) begin : mon
		rsp_t exp_rsp;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (expected_rsps.size() == 0) begin
				mismatch_cnt++;
				$display("%0t: response transfer with none expected, got status=%0d count=%0d empty=%0d",
					$time, rsp.status, rsp.entry_count, rsp.list_empty);
			end else begin
				exp_rsp = expected_rsps.pop_front();
				if (rsp.status !== exp_rsp.status || rsp.entry_count !== exp_rsp.entry_count ||
						rsp.list_empty !== exp_rsp.list_empty) begin
					mismatch_cnt++;
					$display("%0t: mismatch expected status=%0d count=%0d empty=%0d, got status=%0d count=%0d empty=%0d",
						$time, exp_rsp.status, exp_rsp.entry_count, exp_rsp.list_empty,
						rsp.status, rsp.entry_count, rsp.list_empty);
				end
			end
		end
		req_taken = arst_n && req_valid && !req_stall;
		if (req_taken) expected_rsps.push_back(apply_request(req));
	end

	// Stimulus: directed corner cases, then four random phases with different
	// idle/stall pressure. Segments of push-heavy and pop-heavy traffic make
	// the list swing between full and empty.
	initial begin : stim
		int unsigned send_pcts[4];
		int unsigned recv_pcts[4];
		int unsigned mode;
		int unsigned seg_left;
		send_pcts = '{0, 56, 0, 17};
		recv_pcts = '{0, 0, 56, 17};
		value_pool[0] = 32'sh0;
		value_pool[1] = -32'sd1;
		value_pool[2] = 32'sh8000_0000;
		value_pool[3] = 32'sh7fff_ffff;
		value_pool[4] = 32'sd1;
		value_pool[5] = $urandom;

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// pops, search and remove on an empty list
		queue_req(REQ_POP_FRONT, $urandom);
		queue_req(REQ_POP_BACK, $urandom);
		queue_req(REQ_SEARCH, 32'sh0);
		queue_req(REQ_REMOVE, 32'sh0);
		// extremes of the value field, search hit and miss
		queue_req(REQ_PUSH_FRONT, 32'sh8000_0000);
		queue_req(REQ_PUSH_BACK, 32'sh7fff_ffff);
		queue_req(REQ_SEARCH, 32'sh7fff_ffff);
		queue_req(REQ_SEARCH, 32'sd1);
		// remove that matches the front entry: count drops by one only
		queue_req(REQ_REMOVE, 32'sh8000_0000);
		// pop back of a one-entry list empties it
		queue_req(REQ_POP_BACK, $urandom);
		queue_req(REQ_PUSH_BACK, 32'sh0);
		queue_req(REQ_PUSH_BACK, -32'sd1);
		queue_req(REQ_REMOVE, 32'sd1);
		queue_req(REQ_REMOVE, -32'sd1);
		// unused codes leave the list alone
		queue_req(REQ_UNUSED_LO, 32'sh0);
		queue_req(REQ_UNUSED_HI, -32'sd1);
		queue_req(REQ_POP_FRONT, $urandom);
		// fill to capacity, then push on both ends of a full list
		for (int i = 0; i < CAPACITY; i++)
			queue_req(REQ_PUSH_BACK, value_pool[i % 6]);
		queue_req(REQ_PUSH_FRONT, 32'sd1);
		queue_req(REQ_PUSH_BACK, 32'sd1);

		mode = 2;
		seg_left = 0;
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = send_pcts[ph];
			recv_stall_pct = recv_pcts[ph];
			for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
				if (seg_left == 0) begin
					mode = $urandom_range(2);
					seg_left = $urandom_range(60, 25);
				end
				seg_left--;
				pending_reqs.push_back(random_request(mode));
			end
			while (pending_reqs.size() != 0 || req_valid) @(posedge clk);
		end

		// drain outstanding responses, then keep watching for strays
		while (expected_rsps.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatch_cnt == 0 && expected_rsps.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// Watchdog, far beyond the slowest legal run.
	initial begin
		#2_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
